// ===== rtl/core/tepq_pkg.sv =====
// Shared types and constants for the timer expiry queue.
// No dependencies.
package tepq_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  localparam int unsigned OWNER_BITS   = 8;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned MSG_BITS     = OWNER_BITS + PAYLOAD_BITS;
  localparam int unsigned SEQ_BITS     = 64;

endpackage

// ===== rtl/core/tepq_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module tepq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/timer_expiry_priority_queue_top.sv =====
// Timer expiry queue: binary min-heap keyed on {due time, insertion sequence}.
// An add places the new timer at the end and climbs, moving each later-keyed
// parent down; a check that fires with more than one timer queued reads the last
// timer and sifts it down from the root, reading the left and, if present, the right child.
// One word in flight: no new word is taken until the result has been accepted.
// Reset clears counter and occupancy; heap RAM needs no clearing.
// Depends on tepq_pkg and tepq_ram.
module timer_expiry_priority_queue_top
  import tepq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2048,
  parameter int unsigned OWNER_COUNT = 256,
  parameter int unsigned COUNT_BITS  = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // interval[31:0], owner[39:32], payload[71:40]
  input  logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // fired_owner[7:0], fired_payload[39:8],
                                       // nothing_due[40], add_dropped[41], zero[47:42]
  output logic        m_axis_tuser_o   // fired
);

  localparam int unsigned AW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned OW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KW  = COUNT_BITS + SEQ_BITS;
  localparam int unsigned EW  = KW + MSG_BITS;
  localparam int unsigned SW  = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_UP, ST_UP_W, ST_DN_LAST, ST_DN, ST_DN_L, ST_DN_R, ST_DONE
  } state_e;

  function automatic logic key_lt(input logic [EW-1:0] a, input logic [EW-1:0] b);
    return a[EW-1:MSG_BITS] < b[EW-1:MSG_BITS];
  endfunction

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [OW-1:0]         occ_q, occ_d;
  logic [SEQ_BITS-1:0]   seq_q, seq_d;
  logic [EW-1:0]         root_q, root_d;
  logic [EW-1:0]         item_q, item_d;
  logic [EW-1:0]         left_q, left_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic                  nd_q, nd_d;
  logic                  drop_q, drop_d;
  logic                  fired_q, fired_d;
  logic [MSG_BITS-1:0]   fmsg_q, fmsg_d;
  logic                  ovalid_q, ovalid_d;
  logic [47:0]           odata_q, odata_d;
  logic                  ouser_q, ouser_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;

  logic [1:0]            in_mode;
  logic [31:0]           in_interval;
  logic [OWNER_BITS-1:0] in_owner;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic [SW-1:0]         due_sum;
  logic [COUNT_BITS-1:0] due_sat;
  logic [CW-1:0]         lchild, rchild, occ_ext;
  logic [EW-1:0]         cand;
  logic [AW-1:0]         cand_idx;
  logic                  root_nd;

  assign in_mode     = s_axis_tuser_i;
  assign in_interval = s_axis_tdata_i[31:0];
  assign in_owner    = s_axis_tdata_i[39:32];
  assign in_payload  = s_axis_tdata_i[71:40];

  assign due_sum = SW'(tick_q) + SW'(in_interval);
  assign due_sat = (due_sum > SW'(COUNT_MAX)) ? COUNT_MAX : due_sum[COUNT_BITS-1:0];
  assign lchild  = {pos_q, 1'b1};
  assign rchild  = lchild + CW'(1);
  assign occ_ext = CW'(occ_q);
  assign root_nd = (occ_q == '0) || (root_q[EW-1:EW-COUNT_BITS] > tick_q);

  assign s_axis_tready_o = (state_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    tick_d   = tick_q;
    occ_d    = occ_q;
    seq_d    = seq_q;
    item_d   = item_q;
    left_d   = left_q;
    pos_d    = pos_q;
    nd_d     = nd_q;
    drop_d   = drop_q;
    fired_d  = fired_q;
    fmsg_d   = fmsg_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = item_q;
    ram_re    = 1'b0;
    ram_raddr = pos_q;
    cand      = ram_rdata;
    cand_idx  = lchild[AW-1:0];

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          mode_d  = mode_e'(in_mode);
          drop_d  = 1'b0;
          fired_d = 1'b0;
          fmsg_d  = '0;
          state_d = ST_DONE;
          case (mode_e'(in_mode))
            MODE_TICK: begin
              if (tick_q != COUNT_MAX) begin
                tick_d = tick_q + COUNT_BITS'(1);
              end
            end
            MODE_ADD: begin
              if ((occ_q == OW'(QUEUE_DEPTH)) || (32'(in_owner) >= 32'(OWNER_COUNT))) begin
                drop_d = 1'b1;
              end else begin
                item_d  = {due_sat, seq_q, in_owner, in_payload};
                seq_d   = seq_q + SEQ_BITS'(1);
                pos_d   = AW'(occ_q);
                occ_d   = occ_q + OW'(1);
                state_d = ST_UP;
              end
            end
            MODE_CHECK: begin
              nd_d = root_nd;
              if (!root_nd) begin
                fired_d = 1'b1;
                fmsg_d  = root_q[MSG_BITS-1:0];
                occ_d   = occ_q - OW'(1);
                if (occ_q != OW'(1)) begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(occ_q - OW'(1));
                  state_d   = ST_DN_LAST;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_UP: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'((pos_q - AW'(1)) >> 1);
          state_d   = ST_UP_W;
        end
      end
      ST_UP_W: begin
        ram_we = 1'b1;
        if (key_lt(item_q, ram_rdata)) begin
          ram_wdata = ram_rdata;
          pos_d     = AW'((pos_q - AW'(1)) >> 1);
          state_d   = ST_UP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DN_LAST: begin
        item_d  = ram_rdata;
        pos_d   = '0;
        state_d = ST_DN;
      end
      ST_DN: begin
        if (lchild >= occ_ext) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = lchild[AW-1:0];
          state_d   = ST_DN_L;
        end
      end
      ST_DN_L, ST_DN_R: begin
        if (state_q == ST_DN_L && rchild < occ_ext) begin
          left_d    = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = rchild[AW-1:0];
          state_d   = ST_DN_R;
        end else begin
          if (state_q == ST_DN_R) begin
            if (key_lt(ram_rdata, left_q)) begin
              cand     = ram_rdata;
              cand_idx = rchild[AW-1:0];
            end else begin
              cand = left_q;
            end
          end
          ram_we = 1'b1;
          if (key_lt(cand, item_q)) begin
            ram_wdata = cand;
            pos_d     = cand_idx;
            state_d   = ST_DN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        ovalid_d = 1'b1;
        ouser_d  = fired_q;
        odata_d  = {6'b0, drop_q, (mode_q == MODE_CHECK) ? nd_q : root_nd, fmsg_q[31:0],
                    fmsg_q[39:32]};
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    root_d = root_q;
    if (ram_we && ram_waddr == '0) begin
      root_d = ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tick_q   <= '0;
      occ_q    <= '0;
      seq_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      occ_q    <= occ_d;
      seq_q    <= seq_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    root_q  <= root_d;
    item_q  <= item_d;
    left_q  <= left_d;
    pos_q   <= pos_d;
    nd_q    <= nd_d;
    drop_q  <= drop_d;
    fired_q <= fired_d;
    fmsg_q  <= fmsg_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  tepq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

// ===== bench/tb_tepq_checker.sv =====
// Checker for the timer expiry queue: watches both stream channels, predicts
// each result word from a sorted timer list and compares it field by field.
// Depends on tepq_pkg.
module tb_tepq_checker
  import tepq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [71:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  input  logic        m_axis_tuser_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          fired_count_o,
  output int          dropped_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 2048;
  localparam int unsigned OWNERS = 256;
  localparam logic [47:0] COUNT_MAX = '1;

  typedef struct packed {
    logic        fired;
    logic [7:0]  owner;
    logic [31:0] payload;
    logic        nothing_due;
    logic        dropped;
  } expiry_t;

  typedef struct packed {
    logic [47:0] due;
    logic [7:0]  owner;
    logic [31:0] payload;
  } timer_t;

  logic [47:0] ticks;
  timer_t      timers[$];
  expiry_t     expected[$];
  int          fails;
  int          fired_n;
  int          dropped_n;

  assign fail_count_o = fails;
  assign pending_o = expected.size();
  assign fired_count_o = fired_n;
  assign dropped_count_o = dropped_n;

  function automatic logic none_due();
    return timers.size() == 0 || timers[0].due > ticks;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic predict_expiry(input mode_e mode, input logic [71:0] data);
    expiry_t     r;
    timer_t      t;
    logic [48:0] sum;
    int          pos;
    r = '0;
    case (mode)
      MODE_TICK: begin
        if (ticks != COUNT_MAX) ticks++;
        r.nothing_due = none_due();
      end
      MODE_ADD: begin
        if (timers.size() >= DEPTH || data[39:32] >= OWNERS) begin
          r.dropped = 1'b1;
        end else begin
          sum = {1'b0, ticks} + {17'd0, data[31:0]};
          t.due = sum[48] ? COUNT_MAX : sum[47:0];
          t.owner = data[39:32];
          t.payload = data[71:40];
          pos = timers.size();
          while (pos > 0 && timers[pos-1].due > t.due) pos--;
          timers.insert(pos, t);
        end
        r.nothing_due = none_due();
      end
      MODE_CHECK: begin
        r.nothing_due = none_due();
        if (!r.nothing_due) begin
          t = timers.pop_front();
          r.fired = 1'b1;
          r.owner = t.owner;
          r.payload = t.payload;
        end
      end
      default: r.nothing_due = none_due();
    endcase
    expected.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    expiry_t w;
    expiry_t e;
    if (!rst_ni) begin
      ticks = '0;
      timers.delete();
      expected.delete();
      fails = 0;
      fired_n <= 0;
      dropped_n <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        w.fired = m_axis_tuser_i;
        w.owner = m_axis_tdata_i[7:0];
        w.payload = m_axis_tdata_i[39:8];
        w.nothing_due = m_axis_tdata_i[40];
        w.dropped = m_axis_tdata_i[41];
        if (expected.size() == 0) begin
          report_mismatch("unexpected word", 64'(w), '0);
        end else begin
          e = expected.pop_front();
          if (w.fired != e.fired) report_mismatch("fired", 64'(w.fired), 64'(e.fired));
          if (w.owner != e.owner) report_mismatch("owner", 64'(w.owner), 64'(e.owner));
          if (w.payload != e.payload)
            report_mismatch("payload", 64'(w.payload), 64'(e.payload));
          if (w.nothing_due != e.nothing_due)
            report_mismatch("nothing_due", 64'(w.nothing_due), 64'(e.nothing_due));
          if (w.dropped != e.dropped)
            report_mismatch("add_dropped", 64'(w.dropped), 64'(e.dropped));
          if (m_axis_tdata_i[47:42] != '0)
            report_mismatch("pad bits", 64'(m_axis_tdata_i[47:42]), '0);
          if (e.fired) fired_n <= fired_n + 1;
          if (e.dropped) dropped_n <= dropped_n + 1;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_expiry(mode_e'(s_axis_tuser_i), s_axis_tdata_i);
    end
  end
endmodule

// ===== bench/tb_timer_expiry_priority_queue_top.sv =====
// Testbench top for the timer expiry queue: directed and random stream words,
// random idling on both sides, a long output hold-off, and the verdict.
// Depends on tepq_pkg, tb_tepq_checker and the block.
module tb_timer_expiry_priority_queue_top;
  import tepq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] s_data = '0;
  logic [1:0]  s_user = MODE_TICK;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic        m_user;
  int          fails, pending, fired_n, dropped_n;
  int          sent = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold = 1'b0;
  bit          done = 1'b0;

  always #1 clk_i = ~clk_i;

  timer_expiry_priority_queue_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  tb_tepq_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user),
    .fail_count_o(fails), .pending_o(pending),
    .fired_count_o(fired_n), .dropped_count_o(dropped_n)
  );

  // receiver: random stalls, plus a long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) m_ready <= 1'b0;
    else m_ready <= !hold && (calm || $urandom_range(99) >= 33);
  end

  initial begin
    wait (sent >= 120);
    @(posedge clk_i);
    hold = 1'b1;
    repeat (400) @(posedge clk_i);
    hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && !done) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("watchdog expired, %0d words outstanding", pending);
        $display("** timer_expiry_priority_queue_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(input mode_e mode, input logic [31:0] interval,
                           input logic [7:0] owner, input logic [31:0] payload);
    while (!calm && $urandom_range(99) < 33) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= mode;
    s_data <= {payload, owner, interval};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random();
    int          pick;
    logic [31:0] iv;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: iv = $urandom_range(3);
      1: iv = $urandom_range(20);
      2: iv = $urandom;
      default: iv = 32'hFFFF_FFFF - $urandom_range(2);
    endcase
    if (pick < 30) send_word(MODE_TICK, $urandom, 8'($urandom), $urandom);
    else if (pick < 62) send_word(MODE_ADD, iv, 8'($urandom), $urandom);
    else if (pick < 96) send_word(MODE_CHECK, $urandom, 8'($urandom), $urandom);
    else send_word(MODE_NOP, $urandom, 8'($urandom), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_ADD, '0, 8'h00, 32'h8000_0000);
    send_word(MODE_ADD, '0, 8'hFF, 32'h7FFF_FFFF);
    send_word(MODE_ADD, 32'hFFFF_FFFF, 8'hA5, 32'hFFFF_FFFF);
    send_word(MODE_ADD, 32'd2, 8'h5A, 32'h0000_0001);
    send_word(MODE_ADD, 32'd2, 8'h11, 32'h1234_5678);
    send_word(MODE_NOP, '1, '1, '1);
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_TICK, '1, '1, '1);
    send_word(MODE_TICK, '0, '0, '0);
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_ADD, 32'd1, 8'h33, 32'hDEAD_BEEF);
    send_word(MODE_TICK, '0, '0, '0);
    send_word(MODE_CHECK, '0, '0, '0);
    // random, with a calm stretch in the middle
    for (int i = 0; i < 450; i++) begin
      calm = (i >= 200 && i < 260);
      send_random();
    end
    calm = 1'b0;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    done = 1'b1;
    $display("sent %0d words: %0d timers fired, %0d adds refused", sent, fired_n,
             dropped_n);
    if (fails == 0 && pending == 0) begin
      $display("** timer_expiry_priority_queue_top: PASSED **");
    end else begin
      $display("** timer_expiry_priority_queue_top: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/tepq_pkg.sv
rtl/core/tepq_ram.sv
rtl/core/timer_expiry_priority_queue_top.sv
bench/tb_tepq_checker.sv
bench/tb_timer_expiry_priority_queue_top.sv
